/* hw/rtl/quaternion_arith_unit_assert.svh */
// Assertion macros for the quaternion arithmetic unit.
`ifndef QUATERNION_ARITH_UNIT_ASSERT_SVH
`define QUATERNION_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define QAU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qau: check failed");

// Next-cycle implication, checked out of reset
`define QAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qau: check failed");

`endif

/* hw/rtl/qau_pkg.sv */
// Shared constants and types for the quaternion arithmetic unit.
package qau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int MAC_BITS  = 2 * WORD_BITS + 3;
    localparam int RND_VAL   = (1 << FRAC_BITS) >> 1;

    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_MAG  = 3'd3;
    localparam logic [2:0] MODE_EUC  = 3'd4;
    localparam logic [2:0] MODE_CHEB = 3'd5;

    typedef logic signed [WORD_BITS-1:0] word_t;

    // Payload handed from cell to cell along the root chain
    typedef struct packed {
        logic                              valid;
        logic                              root;
        logic                              sat;
        logic [3:0][WORD_BITS-1:0]         res;
        logic [2*WORD_BITS-1:0]            rad;
        logic [WORD_BITS+1:0]              rem;
        logic [WORD_BITS-1:0]              y;
    } cell_t;

endpackage

/* hw/rtl/quaternion_arith_unit.sv */
// Path: front stages A, B and C, then the WORD_BITS root cells, then the output register.
// Throughput: one beat per cycle; the whole pipe advances together, held only
// while the output register is full and not taken.
// Root modes pass a chain of WORD_BITS cells, one root bit per cell.
// Reset clears every valid bit; payload registers are not reset.
module quaternion_arith_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // p_real, p_i, p_j, p_k, q_real, q_i, q_j, q_k
    input  logic [2:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // r_real, r_i, r_j, r_k
    output logic [0:0]   m_tuser    // saturated
);
    import qau_pkg::*;

    `include "quaternion_arith_unit_assert.svh"

    localparam int W = WORD_BITS;
    localparam logic [W:0] WMAX1 = {2'b00, {(W-1){1'b1}}};

    logic              en;
    word_t [3:0]       p;
    word_t [3:0]       q;
    cell_t             chain [W+1];
    logic              out_valid_reg;
    logic [127:0]      out_data_reg;
    logic              out_sat_reg;
    logic [127:0]      out_data_next;
    logic              out_sat_next;
    logic [W:0]        rounded;
    word_t             comp;

    // Advance the pipe unless a result waits untaken
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Take the low word bits of each component
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            p[i] = s_tdata[32*i +: W];
            q[i] = s_tdata[128 + 32*i +: W];
        end
    end

    qau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .mode     (s_tuser),
        .p        (p),
        .q        (q),
        .head     (chain[0])
    );

    for (genvar g = 0; g < W; g++)
    begin : g_cell
        qau_root_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    // Round the root, clip, and sign-extend components to the bus
    always_comb
    begin
        rounded = {1'b0, chain[W].y} +
                  (W+1)'(chain[W].rem[W:0] > {1'b0, chain[W].y});
        out_sat_next = chain[W].sat;
        for (int i = 0; i < 4; i++)
        begin
            comp = chain[W].res[i];
            if (chain[W].root)
            begin
                if (i == 0)
                begin
                    if (rounded > WMAX1)
                    begin
                        comp         = WMAX1[W-1:0];
                        out_sat_next = 1'b1;
                    end
                    else
                    begin
                        comp = rounded[W-1:0];
                    end
                end
                else
                begin
                    comp = '0;
                end
            end
            out_data_next[32*i +: 32] = 32'(comp);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain[W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_sat_reg  <= out_sat_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sat_reg;

    // A root item enters the chain clean: no clip flag, zero side components
    `QAU_ASSERT_NOW(a_head_root_clean, chain[0].valid && chain[0].root,
        !chain[0].sat && chain[0].res == '0 && chain[0].y == '0)
    // The remainder never exceeds twice the settled root
    `QAU_ASSERT_NOW(a_root_rem_bound, chain[W].valid && chain[W].root,
        chain[W].rem <= {1'b0, chain[W].y, 1'b0})
    // A root result leaves as a non-negative scalar
    `QAU_ASSERT_NEXT(a_root_out_pos, en && chain[W].valid && chain[W].root,
        m_tvalid && !m_tdata[W-1] && m_tdata[127:32] == '0)

endmodule

/* hw/rtl/qau_front.sv */
// Front end: sums, products, squares and per-mode results ahead of the root chain.
module qau_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [2:0]                    mode,
    input  qau_pkg::word_t [3:0]          p,
    input  qau_pkg::word_t [3:0]          q,
    output qau_pkg::cell_t                head
);
    import qau_pkg::*;

    localparam int W = WORD_BITS;
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    // stage A
    logic                    a_valid_reg;
    logic [2:0]              a_mode_reg;
    word_t [3:0]             a_p_reg;
    logic signed [W:0]       a_sum_reg [4];
    logic signed [W:0]       a_dif_reg [4];

    // stage B
    logic                    b_valid_reg;
    logic [2:0]              b_mode_reg;
    logic signed [2*W-1:0]   b_prod_reg [16];
    logic [2*W-3:0]          b_sq_reg [4];
    logic                    b_big_reg;
    logic [3:0][W-1:0]       b_lin_reg;
    logic                    b_lin_sat_reg;

    // stage C (head of chain)
    logic                    head_valid_reg;
    cell_t                   head_reg;

    logic [3:0][W-1:0]       lin_next;
    logic                    lin_sat_next;
    logic                    big_next;
    logic [W:0]              mag  [4];
    logic [W:0]              adif [4];
    logic [W:0]              best;
    logic signed [W:0]       pick;
    logic signed [MAC_BITS-1:0] acc [4];
    logic signed [MAC_BITS-1:0] shf [4];
    logic [3:0][W-1:0]       mac_res;
    logic                    mac_sat;
    logic [2*W-1:0]          sumsq;
    cell_t                   head_next;

    // Latch operands, sums and differences
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mode_reg <= mode;
            a_p_reg    <= p;
            for (int i = 0; i < 4; i++)
            begin
                a_sum_reg[i] <= (W+1)'(p[i]) + (W+1)'(q[i]);
                a_dif_reg[i] <= (W+1)'(p[i]) - (W+1)'(q[i]);
            end
        end
    end

    // Clip linear modes, pick magnitudes, find largest difference
    always_comb
    begin
        lin_next     = '0;
        lin_sat_next = 1'b0;
        big_next     = 1'b0;
        best         = '0;
        for (int i = 0; i < 4; i++)
        begin
            adif[i] = a_dif_reg[i][W] ? (W+1)'(-a_dif_reg[i]) : (W+1)'(a_dif_reg[i]);
            if (a_mode_reg == MODE_MAG)
                mag[i] = a_p_reg[i][W-1] ? (W+1)'(-(W+1)'(a_p_reg[i]))
                                         : (W+1)'(a_p_reg[i]);
            else
                mag[i] = adif[i];
            if (mag[i][W] | mag[i][W-1])
                big_next = 1'b1;
            if (adif[i] > best)
                best = adif[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            pick = (a_mode_reg == MODE_ADD) ? a_sum_reg[i] : a_dif_reg[i];
            if (pick[W] != pick[W-1])
            begin
                lin_next[i]  = pick[W] ? WMIN : WMAX;
                lin_sat_next = 1'b1;
            end
            else
            begin
                lin_next[i] = pick[W-1:0];
            end
        end
        if (a_mode_reg == MODE_CHEB)
        begin
            lin_next = '0;
            if (best[W] | best[W-1])
            begin
                lin_next[0]  = WMAX;
                lin_sat_next = 1'b1;
            end
            else
            begin
                lin_next[0]  = best[W-1:0];
                lin_sat_next = 1'b0;
            end
        end
    end

    // Register products, squares and linear results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_mode_reg    <= a_mode_reg;
            b_big_reg     <= big_next;
            b_lin_reg     <= lin_next;
            b_lin_sat_reg <= lin_sat_next;
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    b_prod_reg[i*4+j] <= (2*W)'(a_p_reg[i]) *
                        (2*W)'(signed'(a_sum_reg[j] - a_dif_reg[j]) >>> 1);
                end
                b_sq_reg[i] <= (2*W-2)'(mag[i][W-2:0]) * (2*W-2)'(mag[i][W-2:0]);
            end
        end
    end

    // Sum products with Hamilton signs, round, clip; sum squares
    always_comb
    begin
        acc[0] = MAC_BITS'(b_prod_reg[0])  - MAC_BITS'(b_prod_reg[5])
               - MAC_BITS'(b_prod_reg[10]) - MAC_BITS'(b_prod_reg[15]);
        acc[1] = MAC_BITS'(b_prod_reg[1])  + MAC_BITS'(b_prod_reg[4])
               + MAC_BITS'(b_prod_reg[11]) - MAC_BITS'(b_prod_reg[14]);
        acc[2] = MAC_BITS'(b_prod_reg[2])  + MAC_BITS'(b_prod_reg[8])
               + MAC_BITS'(b_prod_reg[13]) - MAC_BITS'(b_prod_reg[7]);
        acc[3] = MAC_BITS'(b_prod_reg[3])  + MAC_BITS'(b_prod_reg[12])
               + MAC_BITS'(b_prod_reg[6])  - MAC_BITS'(b_prod_reg[9]);
        mac_sat = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            shf[i] = (acc[i] + MAC_BITS'(RND_VAL)) >>> FRAC_BITS;
            if (shf[i][MAC_BITS-1:W-1] != '0 && shf[i][MAC_BITS-1:W-1] != '1)
            begin
                mac_res[i] = shf[i][MAC_BITS-1] ? WMIN : WMAX;
                mac_sat    = 1'b1;
            end
            else
            begin
                mac_res[i] = shf[i][W-1:0];
            end
        end
        sumsq = (2*W)'(b_sq_reg[0]) + (2*W)'(b_sq_reg[1])
              + (2*W)'(b_sq_reg[2]) + (2*W)'(b_sq_reg[3]);

        head_next       = '0;
        head_next.valid = b_valid_reg;
        case (b_mode_reg)
            MODE_ADD, MODE_SUB, MODE_CHEB:
            begin
                head_next.res = b_lin_reg;
                head_next.sat = b_lin_sat_reg;
            end
            MODE_MUL:
            begin
                head_next.res = mac_res;
                head_next.sat = mac_sat;
            end
            MODE_MAG, MODE_EUC:
            begin
                if (b_big_reg)
                begin
                    head_next.res[0] = WMAX;
                    head_next.sat    = 1'b1;
                end
                else
                begin
                    head_next.root = 1'b1;
                    head_next.rad  = sumsq;
                end
            end
            default:
            begin
                head_next.res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            head_valid_reg <= head_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            head_reg <= head_next;
        end
    end

    // Merge the reset valid bit with the payload
    always_comb
    begin
        head       = head_reg;
        head.valid = head_valid_reg;
    end

endmodule

/* hw/rtl/qau_root_cell.sv */
// One cell of the square-root chain: settles one root bit per cell.
module qau_root_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  qau_pkg::cell_t  din,
    output qau_pkg::cell_t  dout
);
    import qau_pkg::*;

    localparam int W = WORD_BITS;

    logic             dout_valid_reg;
    cell_t            dout_reg;
    cell_t            dout_next;
    logic [W+1:0]     rem2;
    logic [W+1:0]     trial;
    logic             ge;

    // Bring down two radicand bits and try the next root bit
    always_comb
    begin
        rem2      = {din.rem[W-1:0], din.rad[2*W-1:2*W-2]};
        trial     = {1'b0, din.y[W-2:0], 2'b01};
        ge        = rem2 >= trial;
        dout_next = din;
        dout_next.rad = {din.rad[2*W-3:0], 2'b00};
        dout_next.rem = ge ? rem2 - trial : rem2;
        dout_next.y   = {din.y[W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dout_valid_reg <= dout_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    // Merge the reset valid bit with the payload
    always_comb
    begin
        dout       = dout_reg;
        dout.valid = dout_valid_reg;
    end

endmodule

/* bench/tb.sv */
// Self-checking bench for the quaternion arithmetic unit.
module tb;
    import qau_pkg::*;

    localparam longint WMAX_L = 64'sd2147483647;
    localparam longint WMIN_L = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] r_real;
        logic [31:0] r_i;
        logic [31:0] r_j;
        logic [31:0] r_k;
        logic        sat;
    } quat_res_t;

    // Golden arithmetic and the queue of results still owed
    class quat_scoreboard;
        quat_res_t owed[$];
        int        mismatches;
        int        checked;

        function longint clip64(longint v, ref logic flag);
            if (v > WMAX_L) begin flag = 1'b1; return WMAX_L; end
            if (v < WMIN_L) begin flag = 1'b1; return WMIN_L; end
            return v;
        endfunction

        function longint mac_round(logic signed [127:0] acc, ref logic flag);
            logic signed [127:0] sh;
            sh = (acc + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (sh > 128'sd2147483647) begin flag = 1'b1; return WMAX_L; end
            if (sh < -128'sd2147483648) begin flag = 1'b1; return WMIN_L; end
            return longint'(sh);
        endfunction

        function longint root_sq(longint m[4], ref logic flag);
            logic [65:0] s;
            logic [65:0] r;
            for (int i = 0; i < 4; i++) begin
                if (m[i] > WMAX_L) begin flag = 1'b1; return WMAX_L; end
            end
            s = 0;
            for (int i = 0; i < 4; i++) s += 66'(m[i]) * 66'(m[i]);
            // floor root by binary search, then round to nearest
            r = 0;
            for (int b = 32; b >= 0; b--)
                if ((r | (66'd1 << b)) * (r | (66'd1 << b)) <= s) r |= 66'd1 << b;
            if (s - r * r > r) r++;
            if (r > 66'(WMAX_L)) begin flag = 1'b1; return WMAX_L; end
            return longint'(r);
        endfunction

        function void note_input(logic [2:0] mode, logic [255:0] d);
            longint p[4], q[4], r[4], m[4];
            logic flag;
            logic signed [127:0] a;
            quat_res_t e;
            flag = 1'b0;
            for (int i = 0; i < 4; i++) begin
                p[i] = longint'($signed(d[32*i +: 32]));
                q[i] = longint'($signed(d[128 + 32*i +: 32]));
                r[i] = 0;
            end
            case (mode)
                MODE_ADD: for (int i = 0; i < 4; i++) r[i] = clip64(p[i] + q[i], flag);
                MODE_SUB: for (int i = 0; i < 4; i++) r[i] = clip64(p[i] - q[i], flag);
                MODE_MUL:
                begin
                    a = 128'(p[0]*q[0]) - 128'(p[1]*q[1]) - 128'(p[2]*q[2])
                        - 128'(p[3]*q[3]);
                    r[0] = mac_round(a, flag);
                    a = 128'(p[0]*q[1]) + 128'(p[1]*q[0]) + 128'(p[2]*q[3])
                        - 128'(p[3]*q[2]);
                    r[1] = mac_round(a, flag);
                    a = 128'(p[0]*q[2]) + 128'(p[2]*q[0]) + 128'(p[3]*q[1])
                        - 128'(p[1]*q[3]);
                    r[2] = mac_round(a, flag);
                    a = 128'(p[0]*q[3]) + 128'(p[3]*q[0]) + 128'(p[1]*q[2])
                        - 128'(p[2]*q[1]);
                    r[3] = mac_round(a, flag);
                end
                MODE_MAG:
                begin
                    for (int i = 0; i < 4; i++) m[i] = p[i] < 0 ? -p[i] : p[i];
                    r[0] = root_sq(m, flag);
                end
                MODE_EUC:
                begin
                    for (int i = 0; i < 4; i++)
                        m[i] = (p[i] - q[i]) < 0 ? q[i] - p[i] : p[i] - q[i];
                    r[0] = root_sq(m, flag);
                end
                MODE_CHEB:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        m[i] = (p[i] - q[i]) < 0 ? q[i] - p[i] : p[i] - q[i];
                        if (m[i] > r[0]) r[0] = m[i];
                    end
                    if (r[0] > WMAX_L) begin flag = 1'b1; r[0] = WMAX_L; end
                end
                default: ;
            endcase
            e.r_real = r[0][31:0];
            e.r_i    = r[1][31:0];
            e.r_j    = r[2][31:0];
            e.r_k    = r[3][31:0];
            e.sat    = flag;
            owed.push_back(e);
        endfunction

        function void check_result(logic [127:0] d, logic s);
            quat_res_t e, g;
            g = {d[31:0], d[63:32], d[95:64], d[127:96], s};
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", g);
                return;
            end
            e = owed.pop_front();
            checked++;
            if (g.r_real !== e.r_real || g.r_i !== e.r_i || g.r_j !== e.r_j ||
                g.r_k !== e.r_k || g.sat !== e.sat) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: exp %h %h %h %h sat %b, got %h %h %h %h sat %b",
                        checked, e.r_real, e.r_i, e.r_j, e.r_k, e.sat,
                        g.r_real, g.r_i, g.r_j, g.r_k, g.sat);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;   // p_real, p_i, p_j, p_k, q_real, q_i, q_j, q_k
    logic [2:0]   s_tuser;   // mode
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // r_real, r_i, r_j, r_k
    logic [0:0]   m_tuser;   // saturated

    quat_scoreboard sb;
    int             sent;
    int             mode_hits[8];

    quaternion_arith_unit u_top (.*);

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Note input beats and check result beats at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready) begin
            sb.note_input(s_tuser, s_tdata);
            mode_hits[s_tuser]++;
        end
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
    end

    // Receiver stall pattern: calm spells, light and heavy back-pressure spells
    initial
    begin
        int phase;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            phase = ($urandom_range(0, 99) < 3) ? $urandom_range(0, 2) : phase;
            case (phase)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hffffffff;
            4: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
            5: return 32'h00010000;
            default: return $urandom;
        endcase
    endfunction

    // Present one beat and hold it until taken
    task automatic send_beat(logic [2:0] mode, logic [255:0] d);
        s_tuser  <= mode;
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sent++;
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Stimulus and end of run
    initial
    begin
        logic [255:0] d;
        int           burst;
        int           wait_cyc;
        sb = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_ADD;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes per mode, reserved modes, one multiply rounding case
        for (int md = 0; md < 8; md++)
        begin
            send_beat(3'(md), {8{32'h7fffffff}});
            send_beat(3'(md), {{4{32'h80000000}}, {4{32'h7fffffff}}});
            send_beat(3'(md), {{4{32'h7fffffff}}, {4{32'h80000000}}});
        end
        send_beat(MODE_MUL, {32'h0, 32'h0, 32'h0, 32'h00008000,
                             32'h0, 32'h0, 32'h0, 32'h00000001});
        idle_gap(3);

        // Random bursts
        while (sent < 925)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
            begin
                for (int w = 0; w < 8; w++) d[32*w +: 32] = pick_word();
                send_beat(($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                          : 3'($urandom_range(0, 5)), d);
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(0, 12));
        end
        s_tvalid <= 1'b0;

        wait_cyc = 0;
        while (sb.owed.size() != 0 && wait_cyc < 20000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        repeat (WORD_BITS + 8) @(posedge clk);
        if (sb.owed.size() != 0) sb.mismatches++;
        $display("covered %0d beats: add %0d sub %0d mul %0d mag %0d euc %0d cheb %0d rsv %0d",
            sent, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
            mode_hits[4], mode_hits[5], mode_hits[6] + mode_hits[7]);
        $display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
